// File: rtl/inverted_page_table_frame_allocator_unit_assert.svh
// assertion macros for the frame allocator top level
// expects clk and arst_n in the scope of use
`ifndef INVERTED_PAGE_TABLE_FRAME_ALLOCATOR_UNIT_ASSERT_SVH
`define INVERTED_PAGE_TABLE_FRAME_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define IPT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define IPT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/ipt_pkg.sv
// shared types and constants of the frame allocator
// no dependencies
`timescale 1ns / 1ps

package ipt_pkg;

	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;
	localparam int PID_W    = 10;
	localparam int VPN_W    = 12;
	localparam int FRAME_W  = 10;
	localparam int COUNT_W  = 11;

	typedef enum logic [KIND_W-1:0] {
		KIND_TRANSLATE = 2'd0,
		KIND_MAP       = 2'd1,
		KIND_UNMAP     = 2'd2,
		KIND_RELEASE   = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_FOUND = 2'd0,
		STATUS_ALLOC = 2'd1,
		STATUS_MISS  = 2'd2,
		STATUS_FULL  = 2'd3
	} status_t;

	// compare outcome for one table entry
	typedef struct packed {
		logic hit;
		logic owned;
		logic free;
	} cmp_t;

endpackage

// File: rtl/ipt_entry_ram.sv
// frame entry memory: one write port, one registered read port
// depends on nothing but its parameters
`timescale 1ns / 1ps

module ipt_entry_ram #(
	parameter int DEPTH  = 1024,
	parameter int WIDTH  = 23,
	parameter int ADDR_W = 10
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/ipt_match_unit.sv
// shared entry compare unit: owner, exact match and free tests
// depends on ipt_pkg
`timescale 1ns / 1ps

module ipt_match_unit
	import ipt_pkg::*;
#(
	parameter int PW = 10,
	parameter int VW = 12
) (
	input  logic          ent_used,
	input  logic [PW-1:0] ent_pid,
	input  logic [VW-1:0] ent_vpn,
	input  logic [PW-1:0] req_pid,
	input  logic [VW-1:0] req_vpn,
	output cmp_t          result
);

	always_comb begin
		result.owned = ent_used && (ent_pid == req_pid);
		result.hit   = result.owned && (ent_vpn == req_vpn);
		result.free  = !ent_used;
	end

endmodule

// File: rtl/inverted_page_table_frame_allocator_unit.sv
// inverted page table with frame allocation; one request at a time
// a hit raises out_valid once the scan reaches the hit frame; a miss, a map miss or a
// release first scans every entry; a result waits while an earlier one is unclaimed
// in_ready returns with the result, so a new request is taken only once the last one
// is done; the single read port of the entry memory sets the pace of one entry per cycle
// reset: asynchronous, then a clearing pass over every entry with in_ready low
`timescale 1ns / 1ps

`include "inverted_page_table_frame_allocator_unit_assert.svh"

module inverted_page_table_frame_allocator_unit
	import ipt_pkg::*;
#(
	parameter int NUM_FRAMES = 1024,
	parameter int PID_BITS   = 10,
	parameter int VPN_BITS   = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [KIND_W-1:0]   kind,
	input  logic [PID_W-1:0]    proc_id,
	input  logic [VPN_W-1:0]    virt_page,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [FRAME_W-1:0]  frame,
	output logic [COUNT_W-1:0]  freed_count
);

	// index width, and stored id widths: ids wider than the ports add nothing
	localparam int FW = $clog2(NUM_FRAMES);
	localparam int PW = (PID_BITS < PID_W) ? PID_BITS : PID_W;
	localparam int VW = (VPN_BITS < VPN_W) ? VPN_BITS : VPN_W;
	localparam int EW = 1 + PW + VW;
	localparam logic [FW:0] LAST_IDX = (FW + 1)'(NUM_FRAMES - 1);
	localparam logic [FW:0] DEPTH_C  = (FW + 1)'(NUM_FRAMES);
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t state_q;

	// request latched on the accept beat
	kind_t         kind_q;
	logic [PW-1:0] pid_q;
	logic [VW-1:0] vpn_q;

	// scan pointer (also the clearing pointer) and the compare stage
	logic [FW:0]   cnt_q;
	logic          chk_v_s1;
	logic [FW-1:0] chk_idx_s1;

	// scan findings
	logic               hit_q;
	logic [FW-1:0]      hit_idx_q;
	logic               free_found_q;
	logic [FW-1:0]      free_idx_q;
	logic [COUNT_W-1:0] freed_q;

	// result register
	logic               out_valid_q;
	status_t            status_q;
	logic [FRAME_W-1:0] frame_q;
	logic [COUNT_W-1:0] freed_out_q;

	// memory ports
	logic          rd_en;
	logic [EW-1:0] rd_data;
	logic          wr_en;
	logic [FW-1:0] wr_addr;
	logic [EW-1:0] wr_data;

	logic          ent_used;
	logic [PW-1:0] ent_pid;
	logic [VW-1:0] ent_vpn;
	cmp_t          cmp;

	logic in_beat;
	logic issue;
	logic last_chk;
	logic out_free;
	logic map_alloc;
	logic unmap_clear;

	// the used bit serves both as entry valid and as the frame-in-use bit:
	// every table write sets or clears the two together
	assign {ent_used, ent_pid, ent_vpn} = rd_data;

	assign in_ready    = (state_q == ST_IDLE);
	assign in_beat     = in_valid && in_ready;
	assign issue       = (state_q == ST_SCAN) && (cnt_q < DEPTH_C);
	assign rd_en       = issue;
	assign last_chk    = chk_v_s1 && ({1'b0, chk_idx_s1} == LAST_IDX);
	assign out_free    = !out_valid_q || out_ready;
	assign map_alloc   = (kind_q == KIND_MAP) && !hit_q && free_found_q;
	assign unmap_clear = (kind_q == KIND_UNMAP) && hit_q;

	// one write port: clearing pass, release clears during the scan, and the
	// single update of map or unmap when the result leaves
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q[FW-1:0];
		wr_data = '0;
		case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
			end
			ST_SCAN: begin
				wr_en   = chk_v_s1 && (kind_q == KIND_RELEASE) && cmp.owned;
				wr_addr = chk_idx_s1;
			end
			ST_FINISH: begin
				wr_en = out_free && (map_alloc || unmap_clear);
				if (map_alloc) begin
					wr_addr = free_idx_q;
					wr_data = {1'b1, pid_q, vpn_q};
				end else begin
					wr_addr = hit_idx_q;
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	ipt_entry_ram #(
		.DEPTH  (NUM_FRAMES),
		.WIDTH  (EW),
		.ADDR_W (FW)
	) u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (cnt_q[FW-1:0]),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	ipt_match_unit #(
		.PW (PW),
		.VW (VW)
	) u_match (
		.ent_used (ent_used),
		.ent_pid  (ent_pid),
		.ent_vpn  (ent_vpn),
		.req_pid  (pid_q),
		.req_vpn  (vpn_q),
		.result   (cmp)
	);

	// frame numbers leave masked to the port width
	function automatic logic [FRAME_W-1:0] to_frame(input logic [FW-1:0] idx);
		logic [FW+FRAME_W-1:0] ext;
		ext = {{FRAME_W{1'b0}}, idx};
		return ext[FRAME_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			cnt_q        <= '0;
			chk_v_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			freed_q      <= '0;
		end else begin
			// a finishing request reloads the result register itself
			if (out_valid_q && out_ready && (state_q != ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_beat) begin
						kind_q       <= kind_t'(kind);
						pid_q        <= proc_id[PW-1:0];
						vpn_q        <= virt_page[VW-1:0];
						cnt_q        <= '0;
						chk_v_s1     <= 1'b0;
						hit_q        <= 1'b0;
						free_found_q <= 1'b0;
						freed_q      <= '0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					chk_v_s1   <= issue;
					chk_idx_s1 <= cnt_q[FW-1:0];
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (chk_v_s1) begin
						if (kind_q == KIND_RELEASE) begin
							if (cmp.owned && (freed_q != COUNT_MAX)) begin
								freed_q <= freed_q + 1'b1;
							end
						end else if (cmp.hit) begin
							hit_q     <= 1'b1;
							hit_idx_q <= chk_idx_s1;
						end
						if (cmp.free && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= chk_idx_s1;
						end
						// lowest match wins, or every entry has been looked at
						if (last_chk || ((kind_q != KIND_RELEASE) && cmp.hit)) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					// wait here while an earlier result is still unclaimed
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						case (kind_q)
							KIND_TRANSLATE: begin
								freed_out_q <= '0;
								if (hit_q) begin
									status_q <= STATUS_FOUND;
									frame_q  <= to_frame(hit_idx_q);
								end else begin
									status_q <= STATUS_MISS;
									frame_q  <= '0;
								end
							end
							KIND_MAP: begin
								freed_out_q <= '0;
								if (hit_q) begin
									status_q <= STATUS_FOUND;
									frame_q  <= to_frame(hit_idx_q);
								end else if (free_found_q) begin
									status_q <= STATUS_ALLOC;
									frame_q  <= to_frame(free_idx_q);
								end else begin
									status_q <= STATUS_FULL;
									frame_q  <= '0;
								end
							end
							KIND_UNMAP: begin
								if (hit_q) begin
									status_q    <= STATUS_FOUND;
									frame_q     <= to_frame(hit_idx_q);
									freed_out_q <= COUNT_W'(1);
								end else begin
									status_q    <= STATUS_MISS;
									frame_q     <= '0;
									freed_out_q <= '0;
								end
							end
							KIND_RELEASE: begin
								frame_q     <= '0;
								freed_out_q <= freed_q;
								if (freed_q != '0) begin
									status_q <= STATUS_FOUND;
								end else begin
									status_q <= STATUS_MISS;
								end
							end
							default: begin
								status_q    <= STATUS_MISS;
								frame_q     <= '0;
								freed_out_q <= '0;
							end
						endcase
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign frame       = frame_q;
	assign freed_count = freed_out_q;

	// an accepted request always starts a scan
	`IPT_ASSERT_NXT(a_accept_scans, in_beat, state_q == ST_SCAN, "accept beat did not start a scan")
	// the entry memory is left alone while no request is at work
	`IPT_ASSERT_IMP(a_idle_no_write, state_q == ST_IDLE, !wr_en, "table written while idle")
	// a freed frame count only comes with a found status
	`IPT_ASSERT_IMP(a_freed_found, out_valid && (freed_count != '0),
		status == STATUS_FOUND, "freed count without found status")
	// no frame is named on a miss or a full table
	`IPT_ASSERT_IMP(a_frame_zero, out_valid && (status == STATUS_MISS || status == STATUS_FULL),
		frame == '0, "frame named on a miss")

endmodule

// File: verif/tb_inverted_page_table_frame_allocator_unit.sv
// self-checking bench for the inverted page table frame allocator
// directed plan with a full-table fill, then random request traffic
// depends on ipt_pkg and inverted_page_table_frame_allocator_unit
`timescale 1ns / 1ps

module tb_inverted_page_table_frame_allocator_unit;
	import ipt_pkg::*;

	localparam int NUM_FRAMES  = 1024;
	localparam int RANDOM_REQS = 400;
	localparam int STALL_LIMIT = 20000;
	localparam int COUNT_MAX   = 2047;
	localparam int PRINT_MAX   = 50;

	// one reply beat as the block returns it
	typedef struct packed {
		status_t               status;
		logic [FRAME_W-1:0]    frame;
		logic [COUNT_W-1:0]    count;
	} table_reply_t;

	// one line of the request plan; fixed_reply set where the answer is typed in
	typedef struct packed {
		kind_t                 kind;
		logic [PID_W-1:0]      pid;
		logic [VPN_W-1:0]      vpn;
		logic                  fixed_reply;
		table_reply_t          reply;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [KIND_W-1:0] kind = KIND_TRANSLATE;
	logic [PID_W-1:0] proc_id = '0;
	logic [VPN_W-1:0] virt_page = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [FRAME_W-1:0] frame;
	logic [COUNT_W-1:0] freed_count;

	// shadow copy of the frame table and its bitmap
	logic ent_valid [NUM_FRAMES];
	logic [PID_W-1:0] ent_pid [NUM_FRAMES];
	logic [VPN_W-1:0] ent_vpn [NUM_FRAMES];
	logic ent_used [NUM_FRAMES];

	table_reply_t replies_due [$];

	// no-idle stretch for both sides
	bit steady = 1'b0;
	int n_errors = 0;
	int n_requests = 0;
	int n_allocs = 0;
	int n_full = 0;
	int n_freed = 0;
	int quiet_cycles = 0;

	always #4 clk = ~clk;

	inverted_page_table_frame_allocator_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.proc_id     (proc_id),
		.virt_page   (virt_page),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.frame       (frame),
		.freed_count (freed_count)
	);

	function automatic void clear_entry(int f);
		ent_valid[f] = 1'b0;
		ent_pid[f] = '0;
		ent_vpn[f] = '0;
		ent_used[f] = 1'b0;
	endfunction

	// applies one request to the shadow table and returns the reply it earns;
	// the block scans upwards so the lowest matching or free frame wins
	function automatic table_reply_t walk_frame_table(kind_t k, logic [PID_W-1:0] p,
			logic [VPN_W-1:0] v);
		table_reply_t r;
		int hit_at;
		int free_at;
		r = '{STATUS_MISS, '0, '0};
		hit_at = NUM_FRAMES;
		free_at = NUM_FRAMES;
		for (int f = NUM_FRAMES - 1; f >= 0; f--) begin
			if (ent_valid[f] && ent_pid[f] == p && ent_vpn[f] == v)
				hit_at = f;
			if (!ent_used[f])
				free_at = f;
		end
		n_requests++;
		case (k)
			KIND_TRANSLATE: begin
				if (hit_at < NUM_FRAMES)
					r = '{STATUS_FOUND, FRAME_W'(hit_at), '0};
			end
			KIND_MAP: begin
				if (hit_at < NUM_FRAMES) begin
					r = '{STATUS_FOUND, FRAME_W'(hit_at), '0};
				end else if (free_at < NUM_FRAMES) begin
					ent_valid[free_at] = 1'b1;
					ent_pid[free_at] = p;
					ent_vpn[free_at] = v;
					ent_used[free_at] = 1'b1;
					r = '{STATUS_ALLOC, FRAME_W'(free_at), '0};
					n_allocs++;
				end else begin
					// table full, nothing changes
					r = '{STATUS_FULL, '0, '0};
					n_full++;
				end
			end
			KIND_UNMAP: begin
				if (hit_at < NUM_FRAMES) begin
					clear_entry(hit_at);
					r = '{STATUS_FOUND, FRAME_W'(hit_at), COUNT_W'(1)};
					n_freed++;
				end
			end
			default: begin
				// release: vpn plays no part, count saturates
				for (int f = 0; f < NUM_FRAMES; f++) begin
					if (ent_valid[f] && ent_pid[f] == p) begin
						clear_entry(f);
						if (r.count < COUNT_W'(COUNT_MAX))
							r.count = r.count + 1'b1;
						n_freed++;
					end
				end
				r.status = (r.count != '0) ? STATUS_FOUND : STATUS_MISS;
			end
		endcase
		return r;
	endfunction

	// holds one request on the input until its beat, then books its reply
	task automatic issue_request(input plan_row_t row);
		table_reply_t shadow_reply;
		while (!steady && $urandom_range(0, 99) < 28) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= row.kind;
		proc_id <= row.pid;
		virt_page <= row.vpn;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		shadow_reply = walk_frame_table(row.kind, row.pid, row.vpn);
		replies_due.push_back(row.fixed_reply ? row.reply : shadow_reply);
	endtask

	// output side back-pressure, sampled by the block at the next edge
	always @(posedge clk)
		out_ready <= steady || ($urandom_range(0, 99) >= 28);

	// reply checker: every beat is held against the oldest booked reply
	always @(posedge clk) begin
		table_reply_t want;
		if (arst_n && out_valid && out_ready) begin
			if (replies_due.size() == 0) begin
				n_errors++;
				if (n_errors <= PRINT_MAX)
					$display("%0t: reply beat with nothing outstanding: status %0d frame %0d count %0d",
						$time, status, frame, freed_count);
			end else begin
				want = replies_due.pop_front();
				if (status !== want.status) begin
					n_errors++;
					if (n_errors <= PRINT_MAX)
						$display("%0t: status expected %0d, got %0d",
							$time, want.status, status);
				end
				if (frame !== want.frame) begin
					n_errors++;
					if (n_errors <= PRINT_MAX)
						$display("%0t: frame expected %0d, got %0d",
							$time, want.frame, frame);
				end
				if (freed_count !== want.count) begin
					n_errors++;
					if (n_errors <= PRINT_MAX)
						$display("%0t: freed_count expected %0d, got %0d",
							$time, want.count, freed_count);
				end
			end
		end
	end

	// watchdog: any beat on either side restarts the count
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $time, quiet_cycles);
			$display("[inverted_page_table_frame_allocator_unit] ERROR");
			$finish;
		end
	end

	initial begin
		plan_row_t plan [$];
		plan_row_t row;
		logic [PID_W-1:0] owner;
		logic [VPN_W-1:0] first_vpn;
		logic [VPN_W-1:0] last_vpn;
		logic [VPN_W-1:0] fill_vpn;
		logic [PID_W-1:0] pid_pool [4];
		logic [VPN_W-1:0] vpn_pool [16];
		int roll;

		for (int f = 0; f < NUM_FRAMES; f++)
			clear_entry(f);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: every lookup misses, release finds nothing
		plan.push_back('{KIND_TRANSLATE, 10'd0, 12'd0, 1'b1, '{STATUS_MISS, 10'd0, 11'd0}});
		plan.push_back('{KIND_UNMAP, 10'd0, 12'd0, 1'b1, '{STATUS_MISS, 10'd0, 11'd0}});
		plan.push_back('{KIND_RELEASE, 10'd0, 12'd0, 1'b1, '{STATUS_MISS, 10'd0, 11'd0}});
		// first allocation takes frame 0, a second map of the same page hits it
		plan.push_back('{KIND_MAP, 10'd0, 12'd0, 1'b1, '{STATUS_ALLOC, 10'd0, 11'd0}});
		plan.push_back('{KIND_MAP, 10'd0, 12'd0, 1'b1, '{STATUS_FOUND, 10'd0, 11'd0}});
		plan.push_back('{KIND_TRANSLATE, 10'd0, 12'd0, 1'b1, '{STATUS_FOUND, 10'd0, 11'd0}});
		// top-of-range ids
		plan.push_back('{KIND_MAP, 10'd1023, 12'd4095, 1'b1, '{STATUS_ALLOC, 10'd1, 11'd0}});
		plan.push_back('{KIND_TRANSLATE, 10'd1023, 12'd4095, 1'b0, '0});
		// half matches must miss
		plan.push_back('{KIND_TRANSLATE, 10'd1023, 12'd0, 1'b1, '{STATUS_MISS, 10'd0, 11'd0}});
		plan.push_back('{KIND_TRANSLATE, 10'd0, 12'd4095, 1'b1, '{STATUS_MISS, 10'd0, 11'd0}});
		plan.push_back('{KIND_MAP, 10'd1023, 12'd0, 1'b0, '0});
		plan.push_back('{KIND_MAP, 10'd1023, 12'd2048, 1'b0, '0});
		// unmap hit frees frame 0, which the next allocation reuses
		plan.push_back('{KIND_UNMAP, 10'd0, 12'd0, 1'b1, '{STATUS_FOUND, 10'd0, 11'd1}});
		plan.push_back('{KIND_TRANSLATE, 10'd0, 12'd0, 1'b0, '0});
		plan.push_back('{KIND_MAP, 10'd5, 12'h555, 1'b0, '0});
		// release frees the three pages of the top process
		plan.push_back('{KIND_RELEASE, 10'd1023, 12'h7ff, 1'b1, '{STATUS_FOUND, 10'd0, 11'd3}});
		plan.push_back('{KIND_TRANSLATE, 10'd1023, 12'd4095, 1'b0, '0});
		plan.push_back('{KIND_MAP, 10'h2aa, 12'haaa, 1'b0, '0});
		plan.push_back('{KIND_UNMAP, 10'h2aa, 12'haaa, 1'b0, '0});
		plan.push_back('{KIND_RELEASE, 10'd5, 12'd0, 1'b0, '0});
		plan.push_back('{KIND_RELEASE, 10'd5, 12'd0, 1'b1, '{STATUS_MISS, 10'd0, 11'd0}});

		// fill every frame for one process; each page number is distinct so
		// each map allocates
		owner = PID_W'($urandom);
		first_vpn = '0;
		last_vpn = '0;
		for (int f = 0; f < NUM_FRAMES; f++) begin
			fill_vpn = {f[9:0], 2'($urandom)};
			if (f == 0)
				first_vpn = fill_vpn;
			last_vpn = fill_vpn;
			plan.push_back('{KIND_MAP, owner, fill_vpn, 1'b0, '0});
		end
		// full table: a new page is refused, an existing one still hits
		plan.push_back('{KIND_MAP, owner ^ 10'd1, 12'd0, 1'b1,
			'{STATUS_FULL, 10'd0, 11'd0}});
		plan.push_back('{KIND_MAP, owner, last_vpn, 1'b1, '{STATUS_FOUND, 10'd1023, 11'd0}});
		plan.push_back('{KIND_TRANSLATE, owner, first_vpn, 1'b0, '0});
		plan.push_back('{KIND_RELEASE, owner, 12'd0, 1'b1, '{STATUS_FOUND, 10'd0, 11'd1024}});

		for (int i = 0; i < plan.size(); i++)
			issue_request(plan[i]);

		// random traffic over a small key pool so maps, hits and unmaps meet;
		// a slice of fully random noise keeps every input bit moving
		pid_pool[0] = '0;
		pid_pool[1] = '1;
		for (int i = 2; i < 4; i++)
			pid_pool[i] = PID_W'($urandom);
		vpn_pool[0] = '0;
		vpn_pool[1] = '1;
		for (int i = 2; i < 16; i++)
			vpn_pool[i] = VPN_W'($urandom);

		for (int i = 0; i < RANDOM_REQS; i++) begin
			steady = (i >= 150 && i < 230);
			roll = $urandom_range(0, 99);
			row = '0;
			row.pid = pid_pool[$urandom_range(0, 3)];
			row.vpn = vpn_pool[$urandom_range(0, 15)];
			if (roll < 40) begin
				row.kind = KIND_MAP;
			end else if (roll < 65) begin
				row.kind = KIND_TRANSLATE;
			end else if (roll < 82) begin
				row.kind = KIND_UNMAP;
			end else if (roll < 88) begin
				row.kind = KIND_RELEASE;
			end else begin
				row.kind = kind_t'($urandom_range(0, 3));
				row.pid = PID_W'($urandom);
				row.vpn = VPN_W'($urandom);
			end
			issue_request(row);
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		// drain, then give a stray beat a full scan to show up
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (NUM_FRAMES + 16) @(posedge clk);

		$display("%0d requests: %0d allocations, %0d refused on a full table, %0d frames freed",
			n_requests, n_allocs, n_full, n_freed);
		$display("%0d mismatches", n_errors);
		if (n_errors == 0)
			$display("[inverted_page_table_frame_allocator_unit] OK");
		else
			$display("[inverted_page_table_frame_allocator_unit] ERROR");
		$finish;
	end

endmodule
